// ----- src/fp2dec_pkg.sv -----
package fp2dec_pkg;

    localparam int DEF_INT_BITS        = 16;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int DEF_MAX_FRAC_DIGITS = 4;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int CFG_W    = 3;

    localparam logic [CFG_W-1:0]  FRAC_DIGITS_RST = 3'd2;
    localparam logic [CHAR_W-1:0] CH_ZERO         = 8'h30;
    localparam logic [CHAR_W-1:0] CH_POINT        = 8'h2E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } t_bcd_ctrl;

    typedef struct packed {
        logic load;
        logic step;
    } t_frac_ctrl;

endpackage

// ----- src/fp2dec_bcd.sv -----
module fp2dec_bcd #(
    parameter int INT_BITS   = fp2dec_pkg::DEF_INT_BITS,
    parameter int INT_DIGITS = (fp2dec_pkg::DEF_INT_BITS * 3) / 10 + 1
) (
    input  logic                             i_clk,
    input  fp2dec_pkg::t_bcd_ctrl            i_ctrl,
    input  logic [INT_BITS-1:0]              i_bin,
    output logic [fp2dec_pkg::DIGIT_W-1:0]   o_top_digit,
    output logic                             o_top_zero
);

    localparam int DW    = fp2dec_pkg::DIGIT_W;
    localparam int BCD_W = INT_DIGITS * DW;

    logic [INT_BITS-1:0] r_bin;
    logic [INT_BITS-1:0] n_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [BCD_W-1:0]    n_bcd;
    logic [BCD_W-1:0]    w_adj;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int k = 0; k < INT_DIGITS; k++) begin
            if (r_bcd[k*DW +: DW] >= DW'(5)) begin
                w_adj[k*DW +: DW] = r_bcd[k*DW +: DW] + DW'(3);
            end else begin
                w_adj[k*DW +: DW] = r_bcd[k*DW +: DW];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            n_bin = i_bin;
            n_bcd = '0;
        end else if (i_ctrl.conv) begin
            n_bin = {r_bin[INT_BITS-2:0], 1'b0};
            n_bcd = {w_adj[BCD_W-2:0], r_bin[INT_BITS-1]};
        end else if (i_ctrl.shift) begin
            n_bcd = {r_bcd[BCD_W-DW-1:0], {DW{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: DW];
    assign o_top_zero  = (r_bcd[BCD_W-1 -: DW] == '0);

endmodule

// ----- src/fp2dec_frac.sv -----
module fp2dec_frac #(
    parameter int FRAC_BITS = fp2dec_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  fp2dec_pkg::t_frac_ctrl           i_ctrl,
    input  logic [FRAC_BITS-1:0]             i_frac,
    output logic [fp2dec_pkg::DIGIT_W-1:0]   o_digit
);

    localparam int DW     = fp2dec_pkg::DIGIT_W;
    localparam int PROD_W = FRAC_BITS + DW;

    logic [FRAC_BITS-1:0] r_frac;
    logic [FRAC_BITS-1:0] n_frac;
    logic [PROD_W-1:0]    w_prod;

    // times ten as eight plus two
    assign w_prod  = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign o_digit = w_prod[PROD_W-1 -: DW];

    always_comb begin
        n_frac = r_frac;
        if (i_ctrl.load) begin
            n_frac = i_frac;
        end else if (i_ctrl.step) begin
            n_frac = w_prod[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_frac <= n_frac;
    end

endmodule

// ----- src/fixed_point_to_decimal_ascii.sv -----
// the first character is registered after the bit-serial binary-to-BCD loop over the integer part
// and the skip of leading zero digits (at most INT_DIGITS - 1 of them)
// a new value is taken only in idle, after the last character of the previous one is registered;
// once the conversion is done, one character per cycle while i_stall does not hold the output
// reset: synchronous active-low, returns to idle, drops any pending output, frac_digits = 2
module fixed_point_to_decimal_ascii #(
    parameter int INT_BITS        = fp2dec_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS       = fp2dec_pkg::DEF_FRAC_BITS,
    parameter int MAX_FRAC_DIGITS = fp2dec_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fp2dec_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [fp2dec_pkg::VALUE_W-1:0]  i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [fp2dec_pkg::CHAR_W-1:0]   o_char_out,
    output logic                            o_last_char
);

    localparam int INT_DIGITS = (INT_BITS * 3) / 10 + 1;
    localparam int CONV_W     = $clog2(INT_BITS + 1);
    localparam int DCNT_W     = $clog2(INT_DIGITS + 1);
    localparam int D_W        = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CW         = fp2dec_pkg::CHAR_W;
    localparam int DW         = fp2dec_pkg::DIGIT_W;
    localparam int VW         = fp2dec_pkg::VALUE_W;

    fp2dec_pkg::t_state     r_state;
    fp2dec_pkg::t_state     n_state;
    fp2dec_pkg::t_bcd_ctrl  w_bcd_ctrl;
    fp2dec_pkg::t_frac_ctrl w_frac_ctrl;

    logic [fp2dec_pkg::CFG_W-1:0] r_frac_digits;
    logic [CONV_W-1:0]            r_conv_cnt;
    logic [CONV_W-1:0]            n_conv_cnt;
    logic [DCNT_W-1:0]            r_dcnt;
    logic [DCNT_W-1:0]            n_dcnt;
    logic [D_W-1:0]               r_digits;
    logic [D_W-1:0]               n_digits;
    logic [D_W-1:0]               w_digits_sat;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [CW-1:0]                r_char;
    logic [CW-1:0]                n_char;
    logic                         r_last;
    logic                         n_last;

    logic [2*VW-1:0]              w_value_ext;
    logic [INT_BITS-1:0]          w_ipart;
    logic [FRAC_BITS-1:0]         w_fpart;
    logic [DW-1:0]                w_int_digit;
    logic                         w_int_zero;
    logic [DW-1:0]                w_frac_digit;
    logic                         w_accept;
    logic                         w_slot;

    assign w_value_ext = {{VW{1'b0}}, i_value};
    assign w_ipart     = w_value_ext[FRAC_BITS +: INT_BITS];
    assign w_fpart     = w_value_ext[FRAC_BITS-1:0];

    assign o_stall  = (r_state != fp2dec_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_slot   = !r_out_valid || !i_stall;

    always_comb begin
        if (int'(r_frac_digits) > MAX_FRAC_DIGITS) begin
            w_digits_sat = D_W'(MAX_FRAC_DIGITS);
        end else begin
            w_digits_sat = D_W'(r_frac_digits);
        end
    end

    fp2dec_bcd #(
        .INT_BITS   (INT_BITS),
        .INT_DIGITS (INT_DIGITS)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_ctrl      (w_bcd_ctrl),
        .i_bin       (w_ipart),
        .o_top_digit (w_int_digit),
        .o_top_zero  (w_int_zero)
    );

    fp2dec_frac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac (
        .i_clk   (i_clk),
        .i_ctrl  (w_frac_ctrl),
        .i_frac  (w_fpart),
        .o_digit (w_frac_digit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fp2dec_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = fp2dec_pkg::ST_CONV;
                end
            end
            fp2dec_pkg::ST_CONV: begin
                if (r_conv_cnt == CONV_W'(1)) begin
                    n_state = fp2dec_pkg::ST_SKIP;
                end
            end
            fp2dec_pkg::ST_SKIP: begin
                if (!w_int_zero || r_dcnt == DCNT_W'(1)) begin
                    n_state = fp2dec_pkg::ST_INT;
                end
            end
            fp2dec_pkg::ST_INT: begin
                if (w_slot && r_dcnt == DCNT_W'(1)) begin
                    if (r_digits != '0) begin
                        n_state = fp2dec_pkg::ST_POINT;
                    end else begin
                        n_state = fp2dec_pkg::ST_IDLE;
                    end
                end
            end
            fp2dec_pkg::ST_POINT: begin
                if (w_slot) begin
                    n_state = fp2dec_pkg::ST_FRAC;
                end
            end
            fp2dec_pkg::ST_FRAC: begin
                if (w_slot && r_digits == D_W'(1)) begin
                    n_state = fp2dec_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fp2dec_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and output register
    always_comb begin
        w_bcd_ctrl  = '0;
        w_frac_ctrl = '0;
        n_conv_cnt  = r_conv_cnt;
        n_dcnt      = r_dcnt;
        n_digits    = r_digits;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            fp2dec_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_bcd_ctrl.load  = 1'b1;
                    w_frac_ctrl.load = 1'b1;
                    n_conv_cnt       = CONV_W'(INT_BITS);
                    n_digits         = w_digits_sat;
                end
            end
            fp2dec_pkg::ST_CONV: begin
                w_bcd_ctrl.conv = 1'b1;
                n_conv_cnt      = r_conv_cnt - CONV_W'(1);
                if (r_conv_cnt == CONV_W'(1)) begin
                    n_dcnt = DCNT_W'(INT_DIGITS);
                end
            end
            fp2dec_pkg::ST_SKIP: begin
                if (w_int_zero && r_dcnt != DCNT_W'(1)) begin
                    w_bcd_ctrl.shift = 1'b1;
                    n_dcnt           = r_dcnt - DCNT_W'(1);
                end
            end
            fp2dec_pkg::ST_INT: begin
                if (w_slot) begin
                    w_bcd_ctrl.shift = 1'b1;
                    n_dcnt           = r_dcnt - DCNT_W'(1);
                    n_out_valid      = 1'b1;
                    n_char           = fp2dec_pkg::CH_ZERO + {{(CW-DW){1'b0}}, w_int_digit};
                    n_last           = (r_dcnt == DCNT_W'(1)) && (r_digits == '0);
                end
            end
            fp2dec_pkg::ST_POINT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = fp2dec_pkg::CH_POINT;
                    n_last      = 1'b0;
                end
            end
            fp2dec_pkg::ST_FRAC: begin
                if (w_slot) begin
                    w_frac_ctrl.step = 1'b1;
                    n_digits         = r_digits - D_W'(1);
                    n_out_valid      = 1'b1;
                    n_char           = fp2dec_pkg::CH_ZERO + {{(CW-DW){1'b0}}, w_frac_digit};
                    n_last           = (r_digits == D_W'(1));
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fp2dec_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_frac_digits <= fp2dec_pkg::FRAC_DIGITS_RST;
            r_conv_cnt    <= '0;
            r_dcnt        <= '0;
            r_digits      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_conv_cnt  <= n_conv_cnt;
            r_dcnt      <= n_dcnt;
            r_digits    <= n_digits;
            if (i_cfg_we) begin
                r_frac_digits <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

endmodule
